// File: design/occ_pkg.sv
package occ_pkg;

	localparam int DIVN_W = 23;
	localparam int DIVD_W = 16;
	localparam int CNT_W = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RMIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RMAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PMIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PMAX = 3'd4;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] OCC_NONE = 8'hFF;
	localparam logic [6:0] OCC_FULL = 7'd127;

endpackage

// File: design/occ_div.sv
module occ_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [occ_pkg::DIVN_W-1:0]  dividend,
	input  logic [occ_pkg::DIVD_W-1:0]  divisor,
	output logic                        done,
	output logic [occ_pkg::DIVN_W-1:0]  quotient
);
	import occ_pkg::*;

	localparam int CW = $clog2(DIVN_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] den_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W:0]   trial;
	logic              ge;
	logic [DIVD_W:0]   diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: design/occupancy_cone_clear_core.sv
// Occupancy grid with cone clearing. A clear command walks the (2W+1)^2 window
// around the base cell, W = min(window_cells, MAX_WINDOW), one offset per cycle;
// a cell that lies in the grid, inside the radius band and on the positive side
// of the heading goes on to ST_CHK, in which the shared multiplier's square
// of the dot product is checked against the cone and the cell memory is
// read-modified-written. A clear passes ST_INIT and ST_LOAD before the walk and
// ST_FIN after it; a read passes ST_RD, ST_RDW and ST_FIN, with ST_DIV before
// ST_FIN when the occupancy needs the bit-serial divider. The block is back in
// idle as the result is loaded; a stalled result holds the next command in its
// final state. After reset the cell memory is cleared one cell a cycle, all
// GRID_W*GRID_H cells, while input stays stalled; configuration writes are
// accepted every cycle and belong between commands.
module occupancy_cone_clear_core #(
	parameter int GRID_W = 64,
	parameter int GRID_H = 64,
	parameter int MAX_WINDOW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [occ_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic signed [10:0]             base_col,
	input  logic signed [10:0]             base_row,
	input  logic signed [15:0]             dir_x,
	input  logic signed [15:0]             dir_y,
	input  logic [14:0]                    dec_amount,
	input  logic [11:0]                    read_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [occ_pkg::CNT_W-1:0]      cells_updated,
	output logic signed [15:0]             stored_prob,
	output logic signed [7:0]              occupancy
);
	import occ_pkg::*;

	localparam int CELLS = GRID_W * GRID_H;
	localparam int AW = $clog2(CELLS);
	localparam int IW = $clog2(MAX_WINDOW + 1) + 1;
	localparam int CW = ((IW > 11) ? IW : 11) + 1;
	localparam int DW = 2 * IW + 1;
	localparam int MW = 16 + IW + 1;
	localparam int PW = 2 * MW;

	typedef enum logic [3:0] {
		ST_WIPE, ST_IDLE, ST_INIT, ST_LOAD, ST_CELL, ST_CHK,
		ST_RD, ST_RDW, ST_DIV, ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]         win_q;
	logic [9:0]         rmin_q;
	logic [9:0]         rmax_q;
	logic signed [15:0] pmin_q;
	logic signed [15:0] pmax_q;

	// command
	logic signed [10:0] bc_q;
	logic signed [10:0] br_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic [14:0]        dec_q;
	logic [11:0]        ridx_q;
	logic signed [IW-1:0] w_q;

	// walk
	logic signed [IW-1:0] i_q;
	logic signed [IW-1:0] j_q;
	logic signed [MW-1:0] dot_q;
	logic signed [MW-1:0] row_q;
	logic [DW-1:0]        d_q;
	logic [AW-1:0]        idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AW-1:0]        wipe_q;
	logic signed [PW-1:0] prod_q;

	// result
	logic [CNT_W-1:0]   res_cnt_q;
	logic signed [15:0] res_prob_q;
	logic [7:0]         res_occ_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic signed [15:0] out_prob_q;
	logic [7:0]         out_occ_q;

	// memory: {touched, prob}
	logic [16:0]   mem [CELLS];
	logic [16:0]   rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [16:0]   wdata;
	logic [AW-1:0] raddr;

	logic signed [MW-1:0] ma;
	logic signed [MW-1:0] mb;
	logic signed [CW-1:0] c;
	logic signed [CW-1:0] r;
	logic signed [2*IW-1:0] ii;
	logic signed [2*IW-1:0] jj;
	logic [DW-1:0] d;
	logic          ingrid;
	logic          band;
	logic          pass;
	logic [AW-1:0] idx_c;
	logic [63:0]   lhs;
	logic [63:0]   rhs;
	logic          cone;
	logic signed [16:0] pnew;
	logic signed [16:0] pclamp;
	logic          last;
	logic signed [IW-1:0] nxt_i;
	logic signed [IW-1:0] nxt_j;
	logic signed [MW-1:0] nxt_dot;
	logic signed [MW-1:0] nxt_row;
	logic          rin;
	logic signed [16:0] num;
	logic signed [16:0] dens;
	logic [15:0]   den;
	logic [15:0]   num16;
	logic          div_start;
	logic [DIVN_W-1:0] div_q;
	logic          div_done;
	logic signed [IW-1:0] w_c;

	assign cfg_ready = 1'b1;
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign cells_updated = out_cnt_q;
	assign stored_prob = out_prob_q;
	assign occupancy = out_occ_q;

	assign w_c = (32'(win_q) > MAX_WINDOW) ? IW'(MAX_WINDOW) : IW'(win_q);

	// cell tests
	assign c = CW'(bc_q) + CW'(i_q);
	assign r = CW'(br_q) + CW'(j_q);
	assign ingrid = (c >= 0) && (c < CW'(GRID_W)) && (r >= 0) && (r < CW'(GRID_H));
	assign ii = i_q * i_q;
	assign jj = j_q * j_q;
	assign d = DW'(ii) + DW'(jj);
	assign band = (32'(rmin_q) < 32'(d)) && (32'(d) < 32'(rmax_q));
	assign pass = ingrid && band && (dot_q > 0);
	assign idx_c = AW'(32'(c) + 32'(GRID_W) * 32'(r));

	assign lhs = 64'(prod_q) << 1;
	assign rhs = 64'(d_q) << 30;
	assign cone = lhs > rhs;
	assign pnew = 17'(signed'(rd_q[15:0])) - 17'(signed'({1'b0, dec_q}));
	assign pclamp = (pnew < 17'(pmin_q)) ? 17'(pmin_q) : pnew;

	// window walk, column offset outer
	assign last = (i_q == w_q) && (j_q == w_q);
	always_comb begin
		nxt_i = i_q;
		nxt_j = j_q + 1'b1;
		nxt_dot = dot_q + MW'(dy_q);
		nxt_row = row_q;
		if (j_q == w_q) begin
			nxt_i = i_q + 1'b1;
			nxt_j = -w_q;
			nxt_row = row_q + MW'(dx_q);
			nxt_dot = row_q + MW'(dx_q);
		end
	end

	// shared multiplier
	always_comb begin
		ma = dot_q;
		mb = dot_q;
		if (state_q == ST_INIT) begin
			ma = MW'(dx_q) + MW'(dy_q);
			mb = MW'(w_q);
		end
	end

	// read path
	assign rin = 32'(ridx_q) < CELLS;
	assign num = 17'(signed'(rd_q[15:0])) - 17'(pmin_q);
	assign dens = 17'(pmax_q) - 17'(pmin_q);
	assign den = (dens < 0) ? 16'(-dens) : dens[15:0];
	assign num16 = num[15:0];
	assign div_start = (state_q == ST_RDW) && rin && rd_q[16] && (den != '0) && (num > 0);

	occ_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num16, 7'd0} - {7'd0, num16}),
		.divisor  (den),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = {1'b1, pclamp[15:0]};
		raddr = idx_c;
		if (state_q == ST_WIPE) begin
			we = 1'b1;
			waddr = wipe_q;
			wdata = '0;
		end else if (state_q == ST_CHK) begin
			we = cone;
		end
		if (state_q == ST_RD) begin
			raddr = AW'(ridx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 5'd8;
			rmin_q <= '0;
			rmax_q <= 10'd64;
			pmin_q <= '0;
			pmax_q <= 16'sd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW: win_q <= cfg_data[4:0];
				REG_RMIN: rmin_q <= cfg_data[9:0];
				REG_RMAX: rmax_q <= cfg_data[9:0];
				REG_PMIN: pmin_q <= cfg_data;
				REG_PMAX: pmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			wipe_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= ma * mb;
			// drop the result after its transfer unless a new one is loaded
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						bc_q <= base_col;
						br_q <= base_row;
						dx_q <= dir_x;
						dy_q <= dir_y;
						dec_q <= dec_amount;
						ridx_q <= read_index;
						w_q <= w_c;
						state_q <= (op == OP_READ) ? ST_RD : ST_INIT;
					end
				end
				ST_INIT: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					row_q <= -MW'(prod_q);
					dot_q <= -MW'(prod_q);
					i_q <= -w_q;
					j_q <= -w_q;
					cnt_q <= '0;
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					d_q <= d;
					idx_q <= idx_c;
					if (pass) begin
						state_q <= ST_CHK;
					end else if (last) begin
						res_cnt_q <= cnt_q;
						res_prob_q <= '0;
						res_occ_q <= '0;
						state_q <= ST_FIN;
					end else begin
						i_q <= nxt_i;
						j_q <= nxt_j;
						dot_q <= nxt_dot;
						row_q <= nxt_row;
					end
				end
				ST_CHK: begin
					if (cone && cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (last) begin
						res_cnt_q <= (cone && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
						res_prob_q <= '0;
						res_occ_q <= '0;
						state_q <= ST_FIN;
					end else begin
						i_q <= nxt_i;
						j_q <= nxt_j;
						dot_q <= nxt_dot;
						row_q <= nxt_row;
						state_q <= ST_CELL;
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					res_cnt_q <= '0;
					res_prob_q <= rin ? signed'(rd_q[15:0]) : '0;
					state_q <= ST_FIN;
					if (!rin || !rd_q[16]) begin
						res_occ_q <= OCC_NONE;
					end else if (den == '0) begin
						res_occ_q <= (num > 0) ? {1'b0, OCC_FULL} : '0;
					end else if (num <= 0) begin
						res_occ_q <= '0;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_occ_q <= (div_q > DIVN_W'(OCC_FULL)) ? {1'b0, OCC_FULL}
							: {1'b0, div_q[6:0]};
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_cnt_q <= res_cnt_q;
						out_prob_q <= res_prob_q;
						out_occ_q <= res_occ_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: verif/occupancy_cone_clear_core_tb.sv
module occupancy_cone_clear_core_tb;
	import occ_pkg::*;

	localparam int GRID_W = 64;
	localparam int GRID_H = 64;
	localparam int MAX_WINDOW = 16;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int RANDOM_ITEMS = 1000;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct packed {
		logic              op;
		logic signed [10:0] base_col;
		logic signed [10:0] base_row;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [14:0]       dec_amount;
		logic [11:0]       read_index;
	} cmd_t;

	typedef struct packed {
		logic [10:0]       cells_updated;
		logic signed [15:0] stored_prob;
		logic signed [7:0]  occupancy;
	} answer_t;

	typedef struct {
		cmd_t    cmd;
		bit      fixed;
		answer_t ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic signed [10:0] base_col = '0;
	logic signed [10:0] base_row = '0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic [14:0] dec_amount = '0;
	logic [11:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CNT_W-1:0] cells_updated;
	logic signed [15:0] stored_prob;
	logic signed [7:0] occupancy;

	occupancy_cone_clear_core #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_WINDOW(MAX_WINDOW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .base_col(base_col),
		.base_row(base_row), .dir_x(dir_x), .dir_y(dir_y), .dec_amount(dec_amount),
		.read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall), .cells_updated(cells_updated),
		.stored_prob(stored_prob), .occupancy(occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow grid and registers
	logic signed [15:0] grid_prob [CELLS];
	bit grid_touched [CELLS];
	logic [4:0] win_reg;
	logic [9:0] rmin_reg, rmax_reg;
	logic signed [15:0] pmin_reg, pmax_reg;

	answer_t answers_due[$];
	int errors = 0;
	longint cycles = 0;
	bit stall_hold = 1'b0;
	int stall_left = 0;

	function automatic logic signed [7:0] occ_of(logic signed [15:0] p);
		int num, den, q;
		num = int'(p) - int'(pmin_reg);
		den = int'(pmax_reg) - int'(pmin_reg);
		if (den < 0) den = -den;
		if (den == 0) return (num > 0) ? 8'sd127 : 8'sd0;
		if (num <= 0) return 8'sd0;
		q = (127 * num) / den;
		return (q > 127) ? 8'sd127 : 8'(q);
	endfunction

	function automatic answer_t apply_cmd(cmd_t c);
		answer_t a;
		int w, col, rw, d, idx, p, cnt;
		longint dot, lhs, rhs;
		a = '0;
		if (c.op == OP_READ) begin
			a.occupancy = OCC_NONE;
			if (c.read_index < CELLS) begin
				a.stored_prob = grid_prob[c.read_index];
				if (grid_touched[c.read_index]) a.occupancy = occ_of(grid_prob[c.read_index]);
			end
			return a;
		end
		w = (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
		cnt = 0;
		for (int i = -w; i <= w; i++) begin
			for (int j = -w; j <= w; j++) begin
				col = int'(c.base_col) + i;
				rw = int'(c.base_row) + j;
				if (col < 0 || col >= GRID_W || rw < 0 || rw >= GRID_H) continue;
				d = i * i + j * j;
				if (!(int'(rmin_reg) < d && d < int'(rmax_reg))) continue;
				dot = longint'(c.dir_x) * i + longint'(c.dir_y) * j;
				if (dot <= 0) continue;
				lhs = 2 * dot * dot;
				rhs = longint'(d) << 30;
				if (!(lhs > rhs)) continue;
				idx = col + GRID_W * rw;
				p = int'(grid_prob[idx]) - int'(c.dec_amount);
				if (p < int'(pmin_reg)) p = pmin_reg;
				grid_prob[idx] = 16'(p);
				grid_touched[idx] = 1'b1;
				if (cnt < 2047) cnt++;
			end
		end
		a.cells_updated = 11'(cnt);
		return a;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall, compare each transfer
	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result cells_updated=%0d", cells_updated);
				errors++;
			end else begin
				exp_a = answers_due.pop_front();
				if (cells_updated !== exp_a.cells_updated) begin
					$error("cells_updated expected %0d actual %0d", exp_a.cells_updated, cells_updated);
					errors++;
				end
				if (stored_prob !== exp_a.stored_prob) begin
					$error("stored_prob expected %0d actual %0d", exp_a.stored_prob, stored_prob);
					errors++;
				end
				if (occupancy !== exp_a.occupancy) begin
					$error("occupancy expected %0d actual %0d", exp_a.occupancy, occupancy);
					errors++;
				end
			end
		end
		if (stall_hold) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 199) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(10, 40);
		end else begin
			out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WINDOW: win_reg = val[4:0];
			REG_RMIN: rmin_reg = val[9:0];
			REG_RMAX: rmax_reg = val[9:0];
			REG_PMIN: pmin_reg = val;
			REG_PMAX: pmax_reg = val;
			default: ;
		endcase
	endtask

	task automatic send_cmd(cmd_t c);
		int g;
		g = gap_len();
		repeat (g) @(posedge clk);
		in_valid <= 1'b1;
		op <= c.op;
		base_col <= c.base_col;
		base_row <= c.base_row;
		dir_x <= c.dir_x;
		dir_y <= c.dir_y;
		dec_amount <= c.dec_amount;
		read_index <= c.read_index;
		do @(posedge clk); while (in_stall);
		answers_due.insert(answers_due.size(), apply_cmd(c));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (answers_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.op = $urandom_range(0, 2) == 0;
		if ($urandom_range(0, 7) == 0) begin
			c.base_col = 11'($urandom);
			c.base_row = 11'($urandom);
		end else begin
			c.base_col = 11'($urandom_range(0, GRID_W + 7)) - 11'sd4;
			c.base_row = 11'($urandom_range(0, GRID_H + 7)) - 11'sd4;
		end
		c.dir_x = 16'($urandom);
		c.dir_y = 16'($urandom);
		c.dec_amount = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 300));
		if ($urandom_range(0, 9) == 0) c.read_index = 12'($urandom);
		else c.read_index = 12'(($urandom_range(0, 15) + c.base_col) & 63)
			+ 12'(GRID_W) * 12'(($urandom_range(0, 15) + c.base_row) & 63);
		return c;
	endfunction

	row_t plan[$];

	function automatic row_t mk(bit o, int bc, int br, int dx, int dy, int dec, int ri,
			bit fx = 0, int cu = 0, int cp = 0, int oc = 0);
		row_t r;
		r.cmd.op = o; r.cmd.base_col = 11'(bc); r.cmd.base_row = 11'(br);
		r.cmd.dir_x = 16'(dx); r.cmd.dir_y = 16'(dy); r.cmd.dec_amount = 15'(dec);
		r.cmd.read_index = 12'(ri);
		r.fixed = fx;
		r.ans.cells_updated = 11'(cu); r.ans.stored_prob = 16'(cp); r.ans.occupancy = 8'(oc);
		return r;
	endfunction

	task automatic run_plan();
		foreach (plan[k]) begin
			send_cmd(plan[k].cmd);
			if (plan[k].fixed && answers_due[$] !== plan[k].ans) begin
				$error("directed row %0d: table expected %h predictor %h", k, plan[k].ans,
					answers_due[$]);
				errors++;
			end
		end
		plan.delete();
	endtask

	initial begin
		for (int k = 0; k < CELLS; k++) begin
			grid_prob[k] = '0;
			grid_touched[k] = 1'b0;
		end
		win_reg = 5'd8; rmin_reg = '0; rmax_reg = 10'd64; pmin_reg = '0; pmax_reg = 16'sd256;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, index zero, last index read, base cell, zero direction
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, -1));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 4095, 1, 0, 0, -1));
		plan.insert(plan.size(), mk(0, 10, 10, 0, 0, 100, 0, 1, 0, 0, 0));
		plan.insert(plan.size(), mk(0, 0, 0, 32767, 0, 32767, 0));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 1));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, -1));
		plan.insert(plan.size(), mk(0, 32, 32, -32768, 0, 50, 0));
		plan.insert(plan.size(), mk(0, 32, 32, 0, -32768, 50, 0));
		plan.insert(plan.size(), mk(0, 32, 32, 23170, 23170, 1, 0));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 32 + 64 * 29));
		plan.insert(plan.size(), mk(0, -1024, -1024, 32767, 32767, 10, 0, 1, 0, 0, 0));
		plan.insert(plan.size(), mk(0, 1023, 1023, -32768, -32768, 10, 0, 1, 0, 0, 0));
		plan.insert(plan.size(), mk(0, 63, 63, -32768, -32768, 10, 0));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 4094));
		run_plan();
		drain();

		// wide window, negative clamp, degenerate scale
		write_reg(REG_WINDOW, 16'd31);
		write_reg(REG_RMIN, 16'd1);
		write_reg(REG_RMAX, 16'd1023);
		write_reg(REG_PMIN, 16'h8000);
		write_reg(REG_PMAX, 16'h7FFF);
		plan.insert(plan.size(), mk(0, 20, 20, 32767, 0, 32767, 0));
		plan.insert(plan.size(), mk(0, 20, 20, 32767, 0, 32767, 0));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 25 + 64 * 20));
		plan.insert(plan.size(), mk(0, 40, 40, -23170, 23170, 5, 0));
		run_plan();
		drain();
		write_reg(REG_PMIN, 16'd100);
		write_reg(REG_PMAX, 16'd100);
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 25 + 64 * 20));
		plan.insert(plan.size(), mk(0, 20, 20, 32767, 0, 1, 0));
		plan.insert(plan.size(), mk(1, 0, 0, 0, 0, 0, 25 + 64 * 20));
		run_plan();
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_reg(REG_WINDOW, 16'd0); write_reg(REG_RMIN, 16'd0);
					write_reg(REG_RMAX, 16'd0); write_reg(REG_PMIN, 16'hFF00);
					write_reg(REG_PMAX, 16'd256); end
				1: begin write_reg(REG_WINDOW, 16'd16); write_reg(REG_RMIN, 16'd0);
					write_reg(REG_RMAX, 16'd1023); write_reg(REG_PMIN, 16'h8000);
					write_reg(REG_PMAX, 16'h8000); end
				2: begin write_reg(REG_WINDOW, 16'($urandom_range(1, 8)));
					write_reg(REG_RMIN, 16'($urandom_range(0, 8)));
					write_reg(REG_RMAX, 16'($urandom_range(4, 100)));
					write_reg(REG_PMIN, 16'($urandom)); write_reg(REG_PMAX, 16'($urandom)); end
				3: begin write_reg(REG_WINDOW, 16'($urandom_range(0, 31)));
					write_reg(REG_RMIN, 16'($urandom)); write_reg(REG_RMAX, 16'($urandom));
					write_reg(REG_PMIN, 16'h7FFF); write_reg(REG_PMAX, 16'h8000); end
				default: begin write_reg(REG_WINDOW, 16'd6); write_reg(REG_RMIN, 16'd2);
					write_reg(REG_RMAX, 16'd40); write_reg(REG_PMIN, 16'hFC00);
					write_reg(REG_PMAX, 16'd512); end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 5; n++) send_cmd(rand_cmd());
			drain();
		end

		stall_hold = 1'b1;
		drain();
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// File: files.f
design/occ_pkg.sv
design/occ_div.sv
design/occupancy_cone_clear_core.sv
verif/occupancy_cone_clear_core_tb.sv
